/* hdl/fss_pkg.sv */
`default_nettype none

package fss_pkg;

   // action codes
   localparam logic [2:0] ACT_FOLD_WRITE = 3'd0;
   localparam logic [2:0] ACT_START      = 3'd1;
   localparam logic [2:0] ACT_PATTERN    = 3'd2;
   localparam logic [2:0] ACT_TEXT       = 3'd3;
   localparam logic [2:0] ACT_END        = 3'd4;

   // reported positions never exceed this, whatever TEXT_MAX is
   localparam int unsigned POSITION_CAP = 65535;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] entry_index;
      logic [7:0] byte_value;
   } fss_req_type;

   typedef struct packed {
      logic [15:0] match_position;
      logic        text_overflow;
      logic        pattern_overflow;
   } fss_rsp_type;

   // item held between the fold lookup and the search core
   typedef struct packed {
      logic       valid;
      logic [2:0] action;
      logic [7:0] folded;
   } fss_stage_type;

endpackage

`default_nettype wire

/* hdl/folded_substring_search.sv */
// Folded substring search.
// Request channel (req_valid/req_ready/req_data) carries one action per beat:
// fold-table write, start search, append pattern byte, text byte, end of text.
// Every pattern and text byte is looked up in the 256-entry fold table, so the
// table must be loaded before the pattern. Only end of text produces a beat on
// the response channel (rsp_valid/rsp_ready/rsp_data): the one-based start of
// the first match (0 if none) plus the text and pattern overflow flags.
// Throughput: one request beat per cycle unless an end of text waits on a
// pending response; the fold-table read port and window shift/compare set it.
// An end of text passes the stage register; its response is then registered.
// A held response does not block requests that produce none; an end of text
// waits in the stage register while the previous response is still pending.
// Synchronous reset clears the pattern length, counters, flags and the stage
// and response valids; fold-table contents are unknown until written.
`default_nettype none

module folded_substring_search #(
   parameter int unsigned PATTERN_MAX = 32,
   parameter int unsigned TEXT_MAX    = 65535
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire fss_pkg::fss_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output fss_pkg::fss_rsp_type      rsp_data
);

   fss_pkg::fss_stage_type stage;
   fss_pkg::fss_rsp_type   result;
   fss_pkg::fss_rsp_type   rsp_data_ff;
   logic                   rsp_valid_ff;
   logic                   result_fire;
   logic                   advance;
   logic                   accept;

   // only an end-of-text beat needs room in the output register
   assign advance = (stage.action != fss_pkg::ACT_END) || !rsp_valid_ff || rsp_ready;
   assign req_ready = !stage.valid || advance;
   assign accept    = req_valid && req_ready;

   fss_fold_stage u_fold (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .advance  (advance),
      .req_data (req_data),
      .stage    (stage)
   );

   fss_search_core #(
      .PATTERN_MAX (PATTERN_MAX),
      .TEXT_MAX    (TEXT_MAX)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage),
      .advance     (advance),
      .result_fire (result_fire),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result_fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* hdl/fss_fold_stage.sv */
`default_nettype none

module fss_fold_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic                advance,
   input  wire fss_pkg::fss_req_type req_data,
   output fss_pkg::fss_stage_type   stage
);

   logic [7:0] fold_mem [256];
   logic       valid_ff;
   logic [2:0] action_ff;
   logic [7:0] folded_ff;

   // the write lands at the accept edge, so the very next beat already sees it
   always_ff @(posedge clock) begin
      if (accept && (req_data.action == fss_pkg::ACT_FOLD_WRITE)) begin
         fold_mem[req_data.entry_index] <= req_data.byte_value;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         folded_ff <= fold_mem[req_data.byte_value];
         action_ff <= req_data.action;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end
   end

   assign stage.valid  = valid_ff;
   assign stage.action = action_ff;
   assign stage.folded = folded_ff;

endmodule

`default_nettype wire

/* hdl/fss_search_core.sv */
`default_nettype none

module fss_search_core #(
   parameter int unsigned PATTERN_MAX = 32,
   parameter int unsigned TEXT_MAX    = 65535
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fss_pkg::fss_stage_type stage,
   input  wire logic                  advance,
   output logic                       result_fire,
   output fss_pkg::fss_rsp_type       result
);

   localparam int unsigned PL_W = $clog2(PATTERN_MAX + 1);
   localparam logic [PL_W-1:0] PL_MAX = PL_W'(PATTERN_MAX);
   localparam logic [15:0] CNT_LIMIT =
      16'((TEXT_MAX > fss_pkg::POSITION_CAP) ? fss_pkg::POSITION_CAP : TEXT_MAX);

   logic             execute;

   // pattern held reversed: entry 0 is the last appended byte, lining up
   // with window entry 0 (newest text byte)
   logic [7:0]       rpat_ff   [PATTERN_MAX];
   logic [7:0]       rpat_in   [PATTERN_MAX];
   logic [7:0]       window_ff [PATTERN_MAX];
   logic [7:0]       window_in [PATTERN_MAX];
   logic [PL_W-1:0]  plen_ff, plen_in;
   logic [15:0]      count_ff, count_in;
   logic             found_ff, found_in;
   logic [15:0]      found_pos_ff, found_pos_in;
   logic             txt_ovf_ff, txt_ovf_in;
   logic             pat_ovf_ff, pat_ovf_in;

   logic [16:0]      count_next;
   logic [16:0]      pos_next;
   logic [PATTERN_MAX-1:0] hit;

   assign execute    = stage.valid && advance;
   assign count_next = 17'(count_ff) + 17'd1;
   assign pos_next   = count_next - 17'(plen_ff) + 17'd1;

   // shifted window and per-tap compare against the reversed pattern
   always_comb begin
      window_in[0] = stage.folded;
      rpat_in[0]   = stage.folded;
      for (int j = 1; j < PATTERN_MAX; j++) begin
         window_in[j] = window_ff[j-1];
         rpat_in[j]   = rpat_ff[j-1];
      end
      for (int j = 0; j < PATTERN_MAX; j++) begin
         hit[j] = (PL_W'(j) >= plen_ff) || (rpat_ff[j] == window_in[j]);
      end
   end

   always_comb begin
      plen_in      = plen_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      found_pos_in = found_pos_ff;
      txt_ovf_in   = txt_ovf_ff;
      pat_ovf_in   = pat_ovf_ff;
      if (execute) begin
         case (stage.action)
            fss_pkg::ACT_START: begin
               plen_in    = '0;
               count_in   = '0;
               found_in   = 1'b0;
               txt_ovf_in = 1'b0;
               pat_ovf_in = 1'b0;
            end
            fss_pkg::ACT_PATTERN: begin
               if (plen_ff >= PL_MAX) begin
                  pat_ovf_in = 1'b1;
               end else begin
                  plen_in = plen_ff + PL_W'(1);
               end
            end
            fss_pkg::ACT_TEXT: begin
               if (count_ff >= CNT_LIMIT) begin
                  txt_ovf_in = 1'b1;
               end else begin
                  count_in = count_next[15:0];
                  if (!found_ff && (count_next >= 17'(plen_ff)) && (&hit)) begin
                     found_in     = 1'b1;
                     found_pos_in = pos_next[15:0];
                  end
               end
            end
            fss_pkg::ACT_END: begin
               count_in   = '0;
               found_in   = 1'b0;
               txt_ovf_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff    <= '0;
         count_ff   <= '0;
         found_ff   <= 1'b0;
         txt_ovf_ff <= 1'b0;
         pat_ovf_ff <= 1'b0;
      end else begin
         plen_ff    <= plen_in;
         count_ff   <= count_in;
         found_ff   <= found_in;
         txt_ovf_ff <= txt_ovf_in;
         pat_ovf_ff <= pat_ovf_in;
      end
   end

   // window taps older than the current text are never compared (count guard),
   // so the window and the pattern need no clearing
   always_ff @(posedge clock) begin
      found_pos_ff <= found_pos_in;
      if (execute && (stage.action == fss_pkg::ACT_TEXT) && (count_ff < CNT_LIMIT)) begin
         window_ff <= window_in;
      end
      if (execute && (stage.action == fss_pkg::ACT_PATTERN) && (plen_ff < PL_MAX)) begin
         rpat_ff <= rpat_in;
      end
   end

   assign result_fire             = execute && (stage.action == fss_pkg::ACT_END);
   assign result.match_position   = found_ff ? found_pos_ff : 16'd0;
   assign result.text_overflow    = txt_ovf_ff;
   assign result.pattern_overflow = pat_ovf_ff;

   a_plen_bound: assert property (@(posedge clock) disable iff (reset)
      plen_ff <= PL_MAX)
      else $error("pattern length beyond storage");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_LIMIT)
      else $error("text count beyond position limit");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (execute && (stage.action == fss_pkg::ACT_START)) |=>
         (plen_ff == '0) && (count_ff == '0) && !found_ff && !pat_ovf_ff && !txt_ovf_ff)
      else $error("start did not clear search state");

   a_found_pos: assert property (@(posedge clock) disable iff (reset)
      $rose(found_ff) |->
         (found_pos_ff == 16'(17'(count_ff) - 17'(plen_ff) + 17'd1)))
      else $error("match position inconsistent with count");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      result_fire |=> (count_ff == '0) && !found_ff && !txt_ovf_ff)
      else $error("end of text did not clear text side");

endmodule

`default_nettype wire
